### rtl/core/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// shared widths, mode bits and helpers for the line pixel stepper
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int COORD_W       = 6;
  localparam int COLOR_W       = 24;
  localparam int MODE_W        = 2;
  localparam int TILE_SIZE_DEF = 64;

  // request type bits
  localparam int MODE_REV_BIT  = 0;  // walk starts at the second endpoint
  localparam int MODE_YMAJ_BIT = 1;  // y is the major axis

  typedef logic [COORD_W-1:0] coord_t;

  // saturate a coordinate to the last position of the tile
  function automatic coord_t clamp_coord(input coord_t v, input coord_t lim);
    clamp_coord = (v > lim) ? lim : v;
  endfunction

endpackage

### rtl/core/lps_divider.sv
// ----------------------------------------------------------------------------
// lps_divider
// restoring divider, one quotient bit per cycle, separate subtractor and comparator
// ----------------------------------------------------------------------------
module lps_divider #(
  parameter int W = lps_pkg::COORD_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy_r,  busy_nxt;
  logic             done_r,  done_nxt;
  logic [CNT_W-1:0] cnt_r,   cnt_nxt;
  logic [W-1:0]     dq_r,    dq_nxt;
  logic [W-1:0]     rem_r,   rem_nxt;
  logic [W-1:0]     dvs_r,   dvs_nxt;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             fits;

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem_r, dq_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(W);
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[W-1:0] : trial[W-1:0];
      dq_nxt  = {dq_r[W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = dq_r;
  assign rem  = rem_r;

endmodule

### rtl/core/line_pixel_stepper.sv
// ----------------------------------------------------------------------------
// line_pixel_stepper
// steps one line segment inside a tile and emits one pixel per major step
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) takes one line request: two endpoints,
//   a color and a walk type (x or y major, from the first or second endpoint)
//   result channel (out_valid / out_stall) gives one pixel per major step,
//   from start+1 up to the end value inclusive; last_pixel marks the final one
//   a request whose major range is empty yields no pixel and leaves the block
//   ready in the next cycle
// timing:
//   after a request is taken the divider splits |d_minor| / d_major into
//   quotient and remainder; the walk then gives one pixel per cycle while
//   the output is not stalled, at most TILE_SIZE-1 pixels per line
//   in_stall is high from the request until the last pixel is loaded into
//   the output register; the next request can enter while that pixel waits
// reset:
//   synchronous, active low; the sequencer goes idle and the output is empty
// stall:
//   a stalled pixel holds in the output register and the walk pauses
// ----------------------------------------------------------------------------
module line_pixel_stepper #(
  parameter int TILE_SIZE = lps_pkg::TILE_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // line request
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lps_pkg::MODE_W-1:0]  in_req_type,
  input  logic [lps_pkg::COORD_W-1:0] in_first_x,
  input  logic [lps_pkg::COORD_W-1:0] in_first_y,
  input  logic [lps_pkg::COORD_W-1:0] in_second_x,
  input  logic [lps_pkg::COORD_W-1:0] in_second_y,
  input  logic [lps_pkg::COLOR_W-1:0] in_line_color,
  // pixel result
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lps_pkg::COORD_W-1:0] out_pixel_x,
  output logic [lps_pkg::COORD_W-1:0] out_pixel_y,
  output logic [lps_pkg::COLOR_W-1:0] out_pixel_color,
  output logic                        out_last_pixel
);

  localparam int CW = lps_pkg::COORD_W;
  localparam lps_pkg::coord_t TILE_LIM = CW'(TILE_SIZE - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0] state_r, state_nxt;

  // request decode
  lps_pkg::coord_t fx, fy, sx, sy;
  lps_pkg::coord_t ax, ay, bx, by;
  lps_pkg::coord_t maj0, maj1, min0, min1;
  lps_pkg::coord_t dmaj, dmin_abs;
  logic            ymaj, rev, neg, nonempty;
  logic            in_acc;

  assign fx = lps_pkg::clamp_coord(in_first_x, TILE_LIM);
  assign fy = lps_pkg::clamp_coord(in_first_y, TILE_LIM);
  assign sx = lps_pkg::clamp_coord(in_second_x, TILE_LIM);
  assign sy = lps_pkg::clamp_coord(in_second_y, TILE_LIM);

  assign ymaj = in_req_type[lps_pkg::MODE_YMAJ_BIT];
  assign rev  = in_req_type[lps_pkg::MODE_REV_BIT];

  // start point a, end point b
  assign ax = rev ? sx : fx;
  assign ay = rev ? sy : fy;
  assign bx = rev ? fx : sx;
  assign by = rev ? fy : sy;

  assign maj0 = ymaj ? ay : ax;
  assign maj1 = ymaj ? by : bx;
  assign min0 = ymaj ? ax : ay;
  assign min1 = ymaj ? bx : by;

  assign nonempty = (maj1 > maj0);
  assign dmaj     = maj1 - maj0;
  assign neg      = (min1 < min0);
  assign dmin_abs = neg ? (min0 - min1) : (min1 - min0);

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // per-line registers
  logic                        ymaj_r,  ymaj_nxt;
  logic                        neg_r,   neg_nxt;
  lps_pkg::coord_t             maj_r,   maj_nxt;    // current major position
  lps_pkg::coord_t             end_r,   end_nxt;
  lps_pkg::coord_t             min0_r,  min0_nxt;
  lps_pkg::coord_t             dmaj_r,  dmaj_nxt;
  lps_pkg::coord_t             q0_r,    q0_nxt;     // per-step quotient
  lps_pkg::coord_t             r0_r,    r0_nxt;     // per-step remainder
  lps_pkg::coord_t             q_r,     q_nxt;      // accumulated minor offset
  lps_pkg::coord_t             r_r,     r_nxt;      // accumulated remainder
  logic [lps_pkg::COLOR_W-1:0] color_r, color_nxt;

  // output register
  logic                        ov_r,    ov_nxt;
  lps_pkg::coord_t             ox_r,    ox_nxt;
  lps_pkg::coord_t             oy_r,    oy_nxt;
  logic [lps_pkg::COLOR_W-1:0] oc_r,    oc_nxt;
  logic                        ol_r,    ol_nxt;

  // divider
  logic            div_done;
  lps_pkg::coord_t div_q, div_r;

  lps_divider #(
    .W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && nonempty),
    .dividend (dmin_abs),
    .divisor  (dmaj),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // one dda step: add the per-step remainder, carry once into the quotient
  logic [CW:0]     r_sum;
  logic            carry;
  lps_pkg::coord_t r_step, q_step, maj_step, minor;
  logic            slot_free;

  assign r_sum     = {1'b0, r_r} + {1'b0, r0_r};
  assign carry     = (r_sum >= {1'b0, dmaj_r});
  assign r_step    = carry ? CW'(r_sum - {1'b0, dmaj_r}) : r_sum[CW-1:0];
  assign q_step    = q_r + q0_r + CW'(carry);
  assign maj_step  = maj_r + CW'(1);
  assign minor     = neg_r ? (min0_r - q_step) : (min0_r + q_step);
  assign slot_free = !ov_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    ymaj_nxt  = ymaj_r;
    neg_nxt   = neg_r;
    maj_nxt   = maj_r;
    end_nxt   = end_r;
    min0_nxt  = min0_r;
    dmaj_nxt  = dmaj_r;
    q0_nxt    = q0_r;
    r0_nxt    = r0_r;
    q_nxt     = q_r;
    r_nxt     = r_r;
    color_nxt = color_r;
    ov_nxt    = ov_r && out_stall;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && nonempty) begin
          state_nxt = ST_DIV;
          ymaj_nxt  = ymaj;
          neg_nxt   = neg;
          maj_nxt   = maj0;
          end_nxt   = maj1;
          min0_nxt  = min0;
          dmaj_nxt  = dmaj;
          q_nxt     = '0;
          r_nxt     = '0;
          color_nxt = in_line_color;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_WALK;
          q0_nxt    = div_q;
          r0_nxt    = div_r;
        end
      end
      ST_WALK: begin
        if (slot_free) begin
          maj_nxt = maj_step;
          q_nxt   = q_step;
          r_nxt   = r_step;
          ov_nxt  = 1'b1;
          ox_nxt  = ymaj_r ? minor : maj_step;
          oy_nxt  = ymaj_r ? maj_step : minor;
          oc_nxt  = color_r;
          ol_nxt  = (maj_step == end_r);
          if (maj_step == end_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    ymaj_r  <= ymaj_nxt;
    neg_r   <= neg_nxt;
    maj_r   <= maj_nxt;
    end_r   <= end_nxt;
    min0_r  <= min0_nxt;
    dmaj_r  <= dmaj_nxt;
    q0_r    <= q0_nxt;
    r0_r    <= r0_nxt;
    q_r     <= q_nxt;
    r_r     <= r_nxt;
    color_r <= color_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oc_r    <= oc_nxt;
    ol_r    <= ol_nxt;
  end

  assign out_valid       = ov_r;
  assign out_pixel_x     = ox_r;
  assign out_pixel_y     = oy_r;
  assign out_pixel_color = oc_r;
  assign out_last_pixel  = ol_r;

endmodule

### rtl/core/lps_checker.sv
// ----------------------------------------------------------------------------
// lps_checker
// port-level checks for the line pixel stepper, bound to the top level
// ----------------------------------------------------------------------------
module lps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [lps_pkg::COORD_W-1:0] out_pixel_x,
  input logic [lps_pkg::COORD_W-1:0] out_pixel_y,
  input logic [lps_pkg::COLOR_W-1:0] out_pixel_color,
  input logic                        out_last_pixel
);

  // a stalled pixel stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("pixel dropped while stalled");

  // a stalled pixel keeps its payload
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pixel_x) && $stable(out_pixel_y) &&
      $stable(out_pixel_color) && $stable(out_last_pixel))
    else $error("stalled pixel changed");

  // while a line is not finished no new request is taken
  a_line_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |-> in_stall)
    else $error("request taken in the middle of a line");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("pixel offered right after reset");

endmodule

bind line_pixel_stepper lps_checker u_lps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pixel_x     (out_pixel_x),
  .out_pixel_y     (out_pixel_y),
  .out_pixel_color (out_pixel_color),
  .out_last_pixel  (out_last_pixel)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the line pixel stepper
// ----------------------------------------------------------------------------
// line requests go in through the valid/stall input channel, and every pixel
// that comes out is checked field by field against a queue filled by a
// behavioral line walker. a short table of directed requests runs first,
// with hand-computed pixels on the trivial rows. after that come random
// requests, mostly well-formed walks of short and full length, with random
// gaps on the request side and random stalls on the pixel side
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_REQS = 460;
  localparam int DIR_ROWS    = 21;

  typedef lps_pkg::coord_t coord_t;
  typedef logic [lps_pkg::COLOR_W-1:0] color_t;

  // walk selection, bit positions follow the package mode bits
  typedef enum logic [lps_pkg::MODE_W-1:0] {
    WALK_X_FWD = 2'd0,
    WALK_X_REV = 2'd1,
    WALK_Y_FWD = 2'd2,
    WALK_Y_REV = 2'd3
  } walk_e;

  // one line request, with an optional hand-computed single pixel
  typedef struct packed {
    walk_e  mode;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    color_t color;
    logic   typed;    // expectation is typed in below, not traced
    logic   has_pix;  // typed row yields exactly one pixel
    coord_t px;
    coord_t py;
  } line_row_t;

  typedef struct {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

  logic   clk;
  logic   rst_n         = 1'b0;
  logic   in_valid      = 1'b0;
  logic   in_stall;
  logic   [lps_pkg::MODE_W-1:0] in_req_type = '0;
  coord_t in_first_x    = '0;
  coord_t in_first_y    = '0;
  coord_t in_second_x   = '0;
  coord_t in_second_y   = '0;
  color_t in_line_color = '0;
  logic   out_valid;
  logic   out_stall     = 1'b0;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  color_t out_pixel_color;
  logic   out_last_pixel;

  pixel_t pending_pixels[$];  // pixels owed by accepted requests, oldest first
  int     fail_count  = 0;
  int     cycle_count = 0;
  logic   calm        = 1'b0;  // no gaps and no stalls while set

  // directed requests: empty walks, one-step lines at the tile corners,
  // full 63-pixel walks in every mode, negative slopes that truncate
  line_row_t directed_rows [DIR_ROWS] = '{
    // empty walks: equal major values, major going backwards
    '{WALK_X_FWD, 6'd5,  6'd5,  6'd5,  6'd9,  24'h000000, 1'b1, 1'b0, 6'd0,  6'd0},
    '{WALK_X_FWD, 6'd9,  6'd3,  6'd2,  6'd3,  24'hFFFFFF, 1'b1, 1'b0, 6'd0,  6'd0},
    '{WALK_X_REV, 6'd2,  6'd3,  6'd9,  6'd3,  24'hFFFFFF, 1'b1, 1'b0, 6'd0,  6'd0},
    '{WALK_Y_FWD, 6'd0,  6'd0,  6'd63, 6'd0,  24'h800001, 1'b1, 1'b0, 6'd0,  6'd0},
    '{WALK_Y_REV, 6'd0,  6'd0,  6'd0,  6'd63, 24'h7FFFFE, 1'b1, 1'b0, 6'd0,  6'd0},
    // single step with the steepest minor jump; start pixel is never emitted
    '{WALK_X_FWD, 6'd0,  6'd0,  6'd1,  6'd63, 24'hFFFFFF, 1'b1, 1'b1, 6'd1,  6'd63},
    '{WALK_X_REV, 6'd1,  6'd0,  6'd0,  6'd63, 24'h000000, 1'b1, 1'b1, 6'd1,  6'd0},
    '{WALK_Y_FWD, 6'd63, 6'd62, 6'd0,  6'd63, 24'h123456, 1'b1, 1'b1, 6'd0,  6'd63},
    '{WALK_Y_REV, 6'd0,  6'd63, 6'd63, 6'd62, 24'hEDCBA9, 1'b1, 1'b1, 6'd0,  6'd63},
    // longest walks, checked by the line walker
    '{WALK_X_FWD, 6'd0,  6'd0,  6'd63, 6'd63, 24'hAAAAAA, 1'b0, 1'b0, 6'd0,  6'd0},
    '{WALK_X_FWD, 6'd0,  6'd63, 6'd63, 6'd0,  24'h555555, 1'b0, 1'b0, 6'd0,  6'd0},
    '{WALK_X_REV, 6'd63, 6'd0,  6'd0,  6'd17, 24'h0F0F0F, 1'b0, 1'b0, 6'd0,  6'd0},
    '{WALK_Y_FWD, 6'd0,  6'd0,  6'd5,  6'd63, 24'hF0F0F0, 1'b0, 1'b0, 6'd0,  6'd0},
    '{WALK_Y_REV, 6'd40, 6'd63, 6'd3,  6'd0,  24'h00FF00, 1'b0, 1'b0, 6'd0,  6'd0},
    // negative minor slopes, division truncates toward zero
    '{WALK_X_FWD, 6'd3,  6'd10, 6'd10, 6'd7,  24'hFF0000, 1'b0, 1'b0, 6'd0,  6'd0},
    '{WALK_Y_FWD, 6'd20, 6'd4,  6'd13, 6'd9,  24'h0000FF, 1'b0, 1'b0, 6'd0,  6'd0},
    // flat lines along the major axis
    '{WALK_X_FWD, 6'd10, 6'd10, 6'd20, 6'd10, 24'h3C3C3C, 1'b0, 1'b0, 6'd0,  6'd0},
    '{WALK_Y_REV, 6'd7,  6'd30, 6'd7,  6'd20, 24'hC3C3C3, 1'b0, 1'b0, 6'd0,  6'd0},
    '{WALK_X_FWD, 6'd0,  6'd63, 6'd63, 6'd63, 24'h000000, 1'b0, 1'b0, 6'd0,  6'd0},
    '{WALK_Y_FWD, 6'd63, 6'd0,  6'd63, 6'd63, 24'hFFFFFF, 1'b0, 1'b0, 6'd0,  6'd0},
    // both endpoints the same
    '{WALK_X_REV, 6'd12, 6'd12, 6'd12, 6'd12, 24'h5A5A5A, 1'b1, 1'b0, 6'd0,  6'd0}
  };

  line_pixel_stepper #(
    .TILE_SIZE(lps_pkg::TILE_SIZE_DEF)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_first_x     (in_first_x),
    .in_first_y     (in_first_y),
    .in_second_x    (in_second_x),
    .in_second_y    (in_second_y),
    .in_line_color  (in_line_color),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_color(out_pixel_color),
    .out_last_pixel (out_last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // walk the line and queue one pixel per major step after the start value
  function automatic void trace_line(input line_row_t row);
    logic   rev;
    logic   ymaj;
    int     ax, ay, bx, by;
    int     maj0, maj1, min0, min1;
    int     dmaj, dmin, minor, m;
    pixel_t pix;
    rev  = row.mode[lps_pkg::MODE_REV_BIT];
    ymaj = row.mode[lps_pkg::MODE_YMAJ_BIT];
    ax   = rev ? row.x1 : row.x0;
    ay   = rev ? row.y1 : row.y0;
    bx   = rev ? row.x0 : row.x1;
    by   = rev ? row.y0 : row.y1;
    maj0 = ymaj ? ay : ax;
    maj1 = ymaj ? by : bx;
    min0 = ymaj ? ax : ay;
    min1 = ymaj ? bx : by;
    dmaj = maj1 - maj0;
    dmin = min1 - min0;
    // an empty major range leaves the loop untouched, so no divide by zero
    for (m = maj0 + 1; m <= maj1; m++) begin
      minor     = min0 + (dmin * (m - maj0)) / dmaj;
      pix.x     = ymaj ? coord_t'(minor) : coord_t'(m);
      pix.y     = ymaj ? coord_t'(m) : coord_t'(minor);
      pix.color = row.color;
      pix.last  = (m == maj1);
      pending_pixels.push_back(pix);
    end
  endfunction

  // random request: mostly walks with a non-empty major range, short ones
  // more often than long ones; the rest are fully random and may be empty
  function automatic line_row_t random_line();
    line_row_t row;
    int        span, s, e, a, b;
    coord_t    sx, sy, ex, ey;
    row       = '0;
    row.mode  = walk_e'($urandom_range(3));
    row.color = color_t'($urandom);
    if ($urandom_range(99) < 10) begin
      row.x0 = coord_t'($urandom_range(63));
      row.y0 = coord_t'($urandom_range(63));
      row.x1 = coord_t'($urandom_range(63));
      row.y1 = coord_t'($urandom_range(63));
    end else begin
      span = ($urandom_range(99) < 75) ? $urandom_range(12, 1) : $urandom_range(63, 1);
      s    = $urandom_range(63 - span);
      e    = s + span;
      a    = $urandom_range(63);
      b    = $urandom_range(63);
      sx   = row.mode[lps_pkg::MODE_YMAJ_BIT] ? coord_t'(a) : coord_t'(s);
      sy   = row.mode[lps_pkg::MODE_YMAJ_BIT] ? coord_t'(s) : coord_t'(a);
      ex   = row.mode[lps_pkg::MODE_YMAJ_BIT] ? coord_t'(b) : coord_t'(e);
      ey   = row.mode[lps_pkg::MODE_YMAJ_BIT] ? coord_t'(e) : coord_t'(b);
      // the walk starts at the second endpoint in the reversed modes
      row.x0 = row.mode[lps_pkg::MODE_REV_BIT] ? ex : sx;
      row.y0 = row.mode[lps_pkg::MODE_REV_BIT] ? ey : sy;
      row.x1 = row.mode[lps_pkg::MODE_REV_BIT] ? sx : ex;
      row.y1 = row.mode[lps_pkg::MODE_REV_BIT] ? sy : ey;
    end
    return row;
  endfunction

  // gap before a request: none during the calm stretch
  function automatic int pick_gap();
    return (!calm && $urandom_range(99) < 17) ? $urandom_range(4, 1) : 0;
  endfunction

  // drive one request and hold it until the block takes it
  task automatic send_line(input line_row_t row, input int gap);
    pixel_t pix;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= row.mode;
    in_first_x    <= row.x0;
    in_first_y    <= row.y0;
    in_second_x   <= row.x1;
    in_second_y   <= row.y1;
    in_line_color <= row.color;
    // pre-edge stall decides acceptance at this edge
    do @(posedge clk); while (in_stall);
    if (row.typed) begin
      if (row.has_pix) begin
        pix.x     = row.px;
        pix.y     = row.py;
        pix.color = row.color;
        pix.last  = 1'b1;
        pending_pixels.push_back(pix);
      end
    end else begin
      trace_line(row);
    end
  endtask

  // stop requesting until every owed pixel has come out
  task automatic wait_for_pixels();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // stimulus
  initial begin
    line_row_t row;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_line(directed_rows[i], pick_gap());
    wait_for_pixels();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      // a long stretch at full rate on both sides
      calm = (n >= 300 && n < 390);
      // hold the requests off once until the output has fully drained
      if (n == 240)
        wait_for_pixels();
      row = random_line();
      send_line(row, pick_gap());
    end
    calm = 1'b0;

    wait_for_pixels();
    // a few spare cycles for any pixel that should not be there
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // pixel side back-pressure
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 17);
  end

  // pixel checker, pre-edge values decide the handshake
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected pixel, expected none, got x=%0d y=%0d color=%06h last=%0b",
                 $time, out_pixel_x, out_pixel_y, out_pixel_color, out_last_pixel);
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", want.x, out_pixel_x);
        check_field("pixel_y", want.y, out_pixel_y);
        check_field("pixel_color", want.color, out_pixel_color);
        check_field("last_pixel", want.last, out_last_pixel);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
